### sv/lfra_pkg.sv
// ----------------------------------------------------------------------------
// lfra_pkg
// Shared types and constants of the lowest-free-room allocator.
// ----------------------------------------------------------------------------
package lfra_pkg;

    localparam int ROOMS_DEF  = 256;
    localparam int GUESTS_DEF = 1024;

    // field widths of the transactions
    localparam int REQ_W    = 1;
    localparam int GUEST_W  = 10;
    localparam int ROOM_W   = 9;
    localparam int STATUS_W = 2;

    // free map is kept as words of FM_W busy bits
    localparam int FM_W  = 16;
    localparam int FM_SH = 4;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ROOM_COUNT = 1'b0;
    localparam logic [ROOM_W-1:0] ROOM_COUNT_RST = 9'd256;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_DEPART = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_GUEST_ROOM = 2'd2;

    typedef enum logic [1:0] {
        RES_HELD,
        RES_FOUND,
        RES_NO_ROOM,
        RES_NO_GUEST
    } t_res_sel;

    typedef struct packed {
        logic     clr_wr;
        logic     req_load;
        logic     scan_first;
        logic     scan_next;
        logic     rel_rd;
        logic     fm_wr_set;
        logic     fm_wr_clr;
        logic     gt_wr_room;
        logic     gt_wr_zero;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_range;
        logic is_depart;
        logic held_zero;
        logic held_bad;
        logic found;
        logic last_word;
        logic out_free;
    } t_sts;

endpackage

### sv/lowest_free_room_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_room_allocator
// Hands the lowest free room to arriving guests and frees it on departure.
// ----------------------------------------------------------------------------
// Input channel s_axis: one event per transaction, tuser = req_type
// (0 arrive, 1 depart), tdata = guest_id. Output channel m_axis: one result
// per event, tdata = room_number and highest_room, tuser = status.
// APB port: room_count at byte address 0, written in the access cycle.
// One event at a time. A held room, a failed departure or an out-of-range
// guest is reported straight from the lookup; a release reads and then writes
// back its free map word; an arrival searches free map words from word 0 up
// (16 rooms per word, one word read per cycle from the free map memory).
// The next event is taken in the cycle after the previous result is loaded
// into the output register, so a stalled receiver holds one result there
// while the next event is already in work; that event then waits for the
// output register to drain.
// After reset a clearing pass over max(GUESTS, ceil(ROOMS/16)) entries (1024
// by default) zeroes the guest table and free map; s_axis_tready stays low
// during it, configuration writes are still taken.
// ----------------------------------------------------------------------------
module lowest_free_room_allocator #(
    parameter int ROOMS  = lfra_pkg::ROOMS_DEF,
    parameter int GUESTS = lfra_pkg::GUESTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [9:0] guest_id
    input  logic                        s_axis_tuser,   // [0] req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // [8:0] room_number, [17:9] highest_room
    output logic [1:0]                  m_axis_tuser,   // [1:0] status
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfra_pkg::APB_AW-1:0] paddr,
    input  logic [lfra_pkg::APB_DW-1:0] pwdata,
    output logic [lfra_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import lfra_pkg::*;

    t_cmd                cmd;
    t_sts                sts;
    logic [ROOM_W-1:0]   room_count;
    logic [ROOM_W-1:0]   room_number;
    logic [ROOM_W-1:0]   highest_room;
    logic [STATUS_W-1:0] status;

    lfra_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_room_count (room_count)
    );

    lfra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfra_dp #(
        .ROOMS  (ROOMS),
        .GUESTS (GUESTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (s_axis_tuser),
        .i_guest_id     (s_axis_tdata[GUEST_W-1:0]),
        .i_room_count   (room_count),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_room_number  (room_number),
        .o_highest_room (highest_room),
        .o_status       (status)
    );

    assign m_axis_tdata = {6'b0, highest_room, room_number};
    assign m_axis_tuser = status;

endmodule

### sv/lfra_regs.sv
// ----------------------------------------------------------------------------
// lfra_regs
// APB register file: holds the room_count register.
// ----------------------------------------------------------------------------
module lfra_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfra_pkg::APB_AW-1:0] paddr,
    input  logic [lfra_pkg::APB_DW-1:0] pwdata,
    output logic [lfra_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [lfra_pkg::ROOM_W-1:0] o_room_count
);
    import lfra_pkg::*;

    logic [ROOM_W-1:0] r_room_count;
    logic              wr_en;

    // register index is the word address; byte offset bits are ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_ROOM_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_count <= ROOM_COUNT_RST;
        end else if (wr_en) begin
            r_room_count <= pwdata[ROOM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ROOM_COUNT && paddr[1:0] == 2'b00) begin
            prdata = APB_DW'(r_room_count);
        end else if (paddr[2] == REG_ROOM_COUNT) begin
            prdata = APB_DW'(r_room_count);
        end
    end

    assign o_room_count = r_room_count;

endmodule

### sv/lfra_ctrl.sv
// ----------------------------------------------------------------------------
// lfra_ctrl
// Sequencer of the allocator: clearing pass, lookup, free map scan, release.
// ----------------------------------------------------------------------------
module lfra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lfra_pkg::t_sts i_sts,
    output lfra_pkg::t_cmd o_cmd
);
    import lfra_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOKUP = 6'b000100,
        S_SCAN   = 6'b001000,
        S_REL    = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                priority if (!i_sts.in_range) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_NO_GUEST;
                    n_state        = S_EMIT;
                end else if (!i_sts.is_depart && !i_sts.held_zero) begin
                    // guest already holds a room: report it, change nothing
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_HELD;
                    n_state        = S_EMIT;
                end else if (!i_sts.is_depart) begin
                    o_cmd.scan_first = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_sts.held_bad) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_NO_GUEST;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.rel_rd = 1'b1;
                    n_state      = S_REL;
                end
            end
            S_SCAN: begin
                priority if (i_sts.found) begin
                    o_cmd.fm_wr_set  = 1'b1;
                    o_cmd.gt_wr_room = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_sel    = RES_FOUND;
                    n_state          = S_EMIT;
                end else if (i_sts.last_word) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_NO_ROOM;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_REL: begin
                o_cmd.fm_wr_clr  = 1'b1;
                o_cmd.gt_wr_zero = 1'b1;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_sel    = RES_HELD;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // a new transaction is taken only once the previous result is staged
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.req_load |=> (r_state == S_LOOKUP))
        else $error("accept did not start a lookup");

    a_scan_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan_first || o_cmd.scan_next) |=> (r_state == S_SCAN))
        else $error("free map read issued outside of scan");

    a_emit_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> (r_state == S_EMIT))
        else $error("staged result not followed by emit");

endmodule

### sv/lfra_dp.sv
// ----------------------------------------------------------------------------
// lfra_dp
// Datapath: guest-to-room table, free map words, lowest free bit search,
// highest room register and the output register.
// ----------------------------------------------------------------------------
module lfra_dp #(
    parameter int ROOMS  = lfra_pkg::ROOMS_DEF,
    parameter int GUESTS = lfra_pkg::GUESTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfra_pkg::t_cmd                i_cmd,
    output lfra_pkg::t_sts                o_sts,
    input  logic                          i_req_type,
    input  logic [lfra_pkg::GUEST_W-1:0]  i_guest_id,
    input  logic [lfra_pkg::ROOM_W-1:0]   i_room_count,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [lfra_pkg::ROOM_W-1:0]   o_room_number,
    output logic [lfra_pkg::ROOM_W-1:0]   o_highest_room,
    output logic [lfra_pkg::STATUS_W-1:0] o_status
);
    import lfra_pkg::*;

    localparam int RW     = $clog2(ROOMS + 1);
    localparam int GW     = $clog2(GUESTS);
    localparam int GXW    = (GW > GUEST_W) ? GW : GUEST_W;
    localparam int NWORDS = (ROOMS + FM_W - 1) / FM_W;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SW     = WAW + FM_SH + 1;
    localparam int CLR_N  = (GUESTS > NWORDS) ? GUESTS : NWORDS;
    localparam int CCW    = $clog2(CLR_N);

    // request
    logic          r_type;
    logic [GW-1:0] r_gidx;
    logic          r_in_range;
    logic [GXW-1:0] gin_ext;
    logic [GW-1:0]  gidx_in;

    // memories
    logic [RW-1:0]   r_gt_mem [GUESTS];
    logic [RW-1:0]   r_held;
    logic [FM_W-1:0] r_fm_mem [NWORDS];
    logic [FM_W-1:0] r_fword;

    // control counters
    logic [CCW-1:0] r_ccnt;
    logic [WAW-1:0] r_wcnt;
    logic [RW-1:0]  r_max;

    // staged result and output register
    logic [RW-1:0]       r_res_room;
    logic [STATUS_W-1:0] r_res_st;
    logic                r_out_valid;
    logic [ROOM_W-1:0]   r_out_room;
    logic [ROOM_W-1:0]   r_out_hi;
    logic [STATUS_W-1:0] r_out_st;

    // search and release signals
    logic [SW-1:0]     n_eff;
    logic [SW-1:0]     base;
    logic [FM_W-1:0]   avail;
    logic [FM_W-1:0]   lowbit;
    logic [FM_SH-1:0]  fidx;
    logic [SW-1:0]     found_room;
    logic [SW-1:0]     hidx;
    logic [WAW-1:0]    hword;
    logic [FM_W-1:0]   held_onehot;
    logic              clr_g;
    logic              clr_w;

    logic              gt_we;
    logic [GW-1:0]     gt_waddr;
    logic [RW-1:0]     gt_wdata;
    logic              fm_we;
    logic [WAW-1:0]    fm_waddr;
    logic [FM_W-1:0]   fm_wdata;
    logic              fm_re;
    logic [WAW-1:0]    fm_raddr;

    assign gin_ext = GXW'(i_guest_id);
    assign gidx_in = gin_ext[GW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_type     <= i_req_type;
            r_gidx     <= gidx_in;
            r_in_range <= (32'(i_guest_id) < GUESTS);
        end
    end

    // effective room count, limited to ROOMS
    always_comb begin
        if (32'(i_room_count) > ROOMS) begin
            n_eff = SW'(ROOMS);
        end else begin
            n_eff = SW'(i_room_count);
        end
    end

    assign base = {1'b0, r_wcnt, {FM_SH{1'b0}}};

    always_comb begin
        for (int b = 0; b < FM_W; b++) begin
            avail[b] = !r_fword[b] && ((base + SW'(b)) < n_eff);
        end
    end

    // isolate lowest available bit, then encode it
    assign lowbit = avail & (~avail + FM_W'(1));

    always_comb begin
        fidx = '0;
        for (int b = 0; b < FM_W; b++) begin
            if (lowbit[b]) begin
                fidx = fidx | FM_SH'(b);
            end
        end
    end

    assign found_room  = base + SW'(fidx) + SW'(1);
    assign hidx        = SW'(r_held) - SW'(1);
    assign hword       = hidx[WAW+FM_SH-1:FM_SH];
    assign held_onehot = FM_W'(1) << hidx[FM_SH-1:0];

    // clearing pass counter
    assign clr_g = i_cmd.clr_wr && (32'(r_ccnt) < GUESTS);
    assign clr_w = i_cmd.clr_wr && (32'(r_ccnt) < NWORDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
        end else if (i_cmd.clr_wr && (32'(r_ccnt) < CLR_N - 1)) begin
            r_ccnt <= r_ccnt + CCW'(1);
        end
    end

    // guest table
    assign gt_we    = clr_g || i_cmd.gt_wr_room || i_cmd.gt_wr_zero;
    assign gt_waddr = i_cmd.clr_wr ? r_ccnt[GW-1:0] : r_gidx;
    assign gt_wdata = i_cmd.gt_wr_room ? RW'(found_room) : '0;

    always_ff @(posedge i_clk) begin
        if (gt_we) begin
            r_gt_mem[gt_waddr] <= gt_wdata;
        end
        if (i_cmd.req_load) begin
            r_held <= r_gt_mem[gidx_in];
        end
    end

    // free map, stored as busy bits so that clearing writes zeros
    always_comb begin
        fm_we    = clr_w || i_cmd.fm_wr_set || i_cmd.fm_wr_clr;
        fm_waddr = r_wcnt;
        fm_wdata = '0;
        priority if (i_cmd.clr_wr) begin
            fm_waddr = r_ccnt[WAW-1:0];
        end else if (i_cmd.fm_wr_set) begin
            fm_waddr = r_wcnt;
            fm_wdata = r_fword | lowbit;
        end else if (i_cmd.fm_wr_clr) begin
            fm_waddr = hword;
            fm_wdata = r_fword & ~held_onehot;
        end else begin
            fm_waddr = r_wcnt;
        end
    end

    always_comb begin
        fm_re    = i_cmd.scan_first || i_cmd.scan_next || i_cmd.rel_rd;
        fm_raddr = '0;
        priority if (i_cmd.scan_next) begin
            fm_raddr = r_wcnt + WAW'(1);
        end else if (i_cmd.rel_rd) begin
            fm_raddr = hword;
        end else begin
            fm_raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_fm_mem[fm_waddr] <= fm_wdata;
        end
        if (fm_re) begin
            r_fword <= r_fm_mem[fm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
        end else if (i_cmd.scan_first) begin
            r_wcnt <= '0;
        end else if (i_cmd.scan_next) begin
            r_wcnt <= r_wcnt + WAW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cmd.fm_wr_set && (found_room > SW'(r_max))) begin
            r_max <= RW'(found_room);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                RES_HELD: begin
                    r_res_room <= r_held;
                    r_res_st   <= ST_OK;
                end
                RES_FOUND: begin
                    r_res_room <= RW'(found_room);
                    r_res_st   <= ST_OK;
                end
                RES_NO_ROOM: begin
                    r_res_room <= '0;
                    r_res_st   <= ST_NO_ROOM;
                end
                RES_NO_GUEST: begin
                    r_res_room <= '0;
                    r_res_st   <= ST_NO_GUEST_ROOM;
                end
                default: begin
                    r_res_room <= '0;
                    r_res_st   <= ST_NO_GUEST_ROOM;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_room <= ROOM_W'(r_res_room);
            r_out_hi   <= ROOM_W'(r_max);
            r_out_st   <= r_res_st;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_room_number  = r_out_room;
    assign o_highest_room = r_out_hi;
    assign o_status       = r_out_st;

    always_comb begin
        o_sts           = '0;
        o_sts.clr_done  = (32'(r_ccnt) == CLR_N - 1);
        o_sts.in_range  = r_in_range;
        o_sts.is_depart = (r_type == REQ_DEPART);
        o_sts.held_zero = (r_held == '0);
        o_sts.held_bad  = (r_held == '0) || (SW'(r_held) > SW'(ROOMS));
        o_sts.found     = |avail;
        o_sts.last_word = ((base + SW'(FM_W)) >= n_eff);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    a_set_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fm_wr_set |-> (lowbit != '0) && $onehot(lowbit))
        else $error("room taken without a free bit");

    a_no_realloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gt_wr_room |-> (r_held == '0))
        else $error("second room given to a guest");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    a_max_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_max >= $past(r_max)))
        else $error("highest room decreased");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lowest_free_room_allocator. Each event accepted on
// s_axis is run through a local allocator model (free map, guest table,
// highest room). The model's result is queued and compared field by field
// with each m_axis transaction. Directed events cover held guests, releases
// above the room count, zero and oversized counts. Random phases then use
// several room counts, random gaps on both sides and one long receiver hold.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lfra_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 200;

    typedef struct packed {
        logic [ROOM_W-1:0]   room;
        logic [ROOM_W-1:0]   highest;
        logic [STATUS_W-1:0] status;
    } t_room_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;   // [9:0] guest_id
    logic              s_axis_tuser = 1'b0; // [0] req_type
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // [8:0] room_number, [17:9] highest_room
    logic [1:0]        m_axis_tuser;        // [1:0] status
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // allocator model state
    bit                room_free_q [ROOMS_DEF];
    logic [ROOM_W-1:0] guest_room_q [GUESTS_DEF];
    logic [ROOM_W-1:0] max_room_q;
    logic [ROOM_W-1:0] room_count_q;

    t_room_result room_expect_q [$];
    int  mismatch_cnt = 0;
    int  idle_cycles = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  hold_req_cnt = 0;
    int  hold_done_cnt = 0;

    lowest_free_room_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void flag_mismatch(input string what, input int want_v,
                                          input int got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %0s: expected %0d, got %0d", what, want_v, got_v);
    endfunction

    // lowest-free allocation; a failed event leaves all state untouched
    function automatic void allocate_room(input logic dep, input logic [GUEST_W-1:0] gid);
        t_room_result      r;
        logic [ROOM_W-1:0] held;
        int                lim;
        int                k;
        r.room   = '0;
        r.status = ST_OK;
        held     = guest_room_q[gid];
        if (int'(gid) >= GUESTS_DEF) begin
            r.status = ST_NO_GUEST_ROOM;
        end else if (dep == REQ_ARRIVE) begin
            if (held != 0) begin
                r.room = held;
            end else begin
                lim = (int'(room_count_q) > ROOMS_DEF) ? ROOMS_DEF : int'(room_count_q);
                k = 0;
                while (k < lim && !room_free_q[k]) k++;
                if (k < lim) begin
                    room_free_q[k]    = 1'b0;
                    r.room            = ROOM_W'(k + 1);
                    guest_room_q[gid] = ROOM_W'(k + 1);
                    if (ROOM_W'(k + 1) > max_room_q) max_room_q = ROOM_W'(k + 1);
                end else begin
                    r.status = ST_NO_ROOM;
                end
            end
        end else if (held == 0 || int'(held) > ROOMS_DEF) begin
            r.status = ST_NO_GUEST_ROOM;
        end else begin
            room_free_q[held - 1] = 1'b1;
            guest_room_q[gid]     = '0;
            r.room                = held;
        end
        r.highest = max_room_q;
        room_expect_q = {room_expect_q, r};
    endfunction

    // tvalid stays high on return so back-to-back events need no extra edge;
    // callers that wait for anything else go through drain_results first
    task automatic send_event(input logic dep, input logic [GUEST_W-1:0] gid);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= dep;
        s_axis_tdata  <= {6'b0, gid};
        do @(posedge i_clk); while (!s_axis_tready);
        allocate_room(dep, gid);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (room_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_room_count(input logic [ROOM_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(4 * int'(REG_ROOM_COUNT));
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        room_count_q = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // guests come mostly from a window of pool ids, a tenth from anywhere
    task automatic run_random_phase(input logic [ROOM_W-1:0] count, input int n_items,
                                    input int pool, input int arrive_pct, input bit quiet);
        logic               dep;
        logic [GUEST_W-1:0] gid;
        int                 base;
        drain_results();
        write_room_count(count);
        tx_quiet = quiet;
        rx_quiet = quiet;
        base = $urandom_range(0, GUESTS_DEF - pool);
        repeat (n_items) begin
            dep = (int'($urandom_range(99)) < arrive_pct) ? REQ_ARRIVE : REQ_DEPART;
            if ($urandom_range(9) == 0) gid = GUEST_W'($urandom);
            else gid = GUEST_W'(base + int'($urandom_range(0, pool - 1)));
            send_event(dep, gid);
        end
        drain_results();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_directed();
        send_event(REQ_ARRIVE, 10'd0);      // room 1
        send_event(REQ_ARRIVE, 10'd1023);   // room 2
        send_event(REQ_ARRIVE, 10'h155);    // room 3
        send_event(REQ_ARRIVE, 10'd0);      // already held, room 1 again
        send_event(REQ_DEPART, 10'd0);      // frees room 1
        send_event(REQ_DEPART, 10'd0);      // holds nothing now
        send_event(REQ_DEPART, 10'h2AA);    // never arrived
        send_event(REQ_ARRIVE, 10'h2AA);    // reuses room 1
        drain_results();
        write_room_count(9'd1);
        send_event(REQ_ARRIVE, 10'd7);      // only room taken
        send_event(REQ_DEPART, 10'd1023);   // room above count still released
        send_event(REQ_DEPART, 10'h2AA);
        send_event(REQ_ARRIVE, 10'd7);      // room 1
        drain_results();
        write_room_count(9'd0);
        send_event(REQ_ARRIVE, 10'd8);      // nothing searchable
        send_event(REQ_ARRIVE, 10'd7);      // held room still reported
        drain_results();
        write_room_count(9'h1FF);           // clipped to all rooms
        send_event(REQ_ARRIVE, 10'd8);
        send_event(REQ_DEPART, 10'h155);
        send_event(REQ_DEPART, 10'd7);
        send_event(REQ_DEPART, 10'd8);
        drain_results();
    endtask

    task automatic test_fill_all_rooms();
        run_random_phase(9'd256, 400, GUESTS_DEF, 85, 1'b0);
    endtask

    task automatic test_single_room();
        run_random_phase(9'd1, 100, 4, 50, 1'b1);
    endtask

    task automatic test_zero_rooms();
        run_random_phase(9'd0, 40, 64, 60, 1'b0);
    endtask

    task automatic test_count_above_range();
        run_random_phase(9'h1FF, 150, 64, 55, 1'b0);
    endtask

    task automatic test_small_count();
        run_random_phase(9'd17, 150, 40, 50, 1'b0);
    endtask

    task automatic test_count_lowered_while_held();
        run_random_phase(9'd5, 150, GUESTS_DEF, 40, 1'b0);
    endtask

    // receiver stops for a long stretch while events keep coming
    task automatic test_backpressure();
        hold_req_cnt <= hold_req_cnt + 1;
        run_random_phase(9'd256, 40, 64, 70, 1'b1);
    endtask

    // receiver: random gaps, bursts of readiness, one long hold on request
    initial begin : rx_side
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_req_cnt != hold_done_cnt) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_done_cnt++;
            end else begin
                gap = pick_gap(rx_quiet);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 7)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_room_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (room_expect_q.size() == 0) begin
                flag_mismatch("result with no pending event", 0, int'(m_axis_tdata[8:0]));
            end else begin
                want = room_expect_q.pop_front();
                if (m_axis_tdata[8:0] !== want.room)
                    flag_mismatch("room_number", want.room, m_axis_tdata[8:0]);
                if (m_axis_tdata[17:9] !== want.highest)
                    flag_mismatch("highest_room", want.highest, m_axis_tdata[17:9]);
                if (m_axis_tuser !== want.status)
                    flag_mismatch("status", want.status, m_axis_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < ROOMS_DEF; i++) room_free_q[i] = 1'b1;
        for (int i = 0; i < GUESTS_DEF; i++) guest_room_q[i] = '0;
        max_room_q   = '0;
        room_count_q = ROOM_COUNT_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_all_rooms();
        test_single_room();
        test_zero_rooms();
        test_count_above_range();
        test_small_count();
        test_count_lowered_while_held();
        test_backpressure();

        drain_results();
        repeat (30) @(posedge i_clk);
        if (mismatch_cnt == 0 && room_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
